/* hdl/cnm_pkg.sv */
// Package for the comfort noise mixer: widths, sequencer codes, control word
// and the fixed shaping filter coefficients. No dependencies.
package cnm_pkg;

  localparam int STATE_WIDTH_DEF = 40;
  localparam int SAMPLE_W        = 16;
  localparam int WORD_W          = 16;
  localparam int GAIN_W          = 18;
  localparam int COEF_W          = 16;
  localparam int DLY_RST_W       = 18;
  localparam int NUM_SECTIONS    = 3;
  localparam int SEC_W           = 2;
  localparam int STEP_W          = 3;
  localparam int FRAC_BITS       = 14;
  localparam int ROUND_Q14       = 8192;
  localparam int Q2_SHIFT        = 12;
  localparam int ROUND_Q2        = 2048;
  localparam int MIX_SHIFT       = 18;
  localparam int NOISE_OFFSET    = 32768;
  localparam int SAMPLE_MAX      = 32767;
  localparam int SAMPLE_MIN      = -32768;

  typedef logic [SEC_W-1:0] sec_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_MIX_MUL,
    ST_MIX_ACC,
    ST_MIX_OUT
  } state_t;

  typedef enum logic [STEP_W-1:0] {
    SP_MUL_B0,
    SP_MUL_B1,
    SP_OUT_Y,
    SP_MUL_A1,
    SP_MUL_B2,
    SP_UPD_D0,
    SP_ACC_A2,
    SP_UPD_D1
  } step_t;

  typedef enum logic [2:0] {
    CO_B0,
    CO_B1,
    CO_B2,
    CO_NA1,
    CO_NA2
  } coef_sel_t;

  typedef enum logic [1:0] {
    OPB_X,
    OPB_Y,
    OPB_YQ2
  } opb_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_RND,
    ACC_ADD,
    ACC_LOAD_MIX
  } acc_op_t;

  typedef struct packed {
    coef_sel_t coef;
    opb_sel_t  opb;
    acc_op_t   acc_op;
    logic      y_we;
    logic      d0_we;
    logic      d1_we;
    logic      x_adv;
    logic      out_load;
  } ctrl_t;

  // Feedback coefficients are stored negated so every term is accumulated.
  function automatic logic signed [COEF_W-1:0] coef_lookup(input sec_idx_t sec,
                                                           input coef_sel_t sel);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (sec)
      2'd0: begin
        case (sel)
          CO_B0:   c = 16'sd16944;
          CO_B1:   c = -16'sd30007;
          CO_B2:   c = 16'sd13358;
          CO_NA1:  c = 16'sd30081;
          CO_NA2:  c = -16'sd13844;
          default: c = '0;
        endcase
      end
      2'd1: begin
        case (sel)
          CO_B0:   c = 16'sd12060;
          CO_B1:   c = -16'sd14226;
          CO_B2:   c = 16'sd8059;
          CO_NA1:  c = 16'sd14226;
          CO_NA2:  c = -16'sd3736;
          default: c = '0;
        endcase
      end
      2'd2: begin
        case (sel)
          CO_B0:   c = 16'sd9322;
          CO_B1:   c = 16'sd18647;
          CO_B2:   c = 16'sd9322;
          CO_NA1:  c = -16'sd15447;
          CO_NA2:  c = -16'sd5461;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [DLY_RST_W-1:0] delay_reset(input sec_idx_t sec);
    logic signed [DLY_RST_W-1:0] v;
    case (sec)
      2'd0:    v = 18'sd49152;
      2'd1:    v = 18'sd32768;
      2'd2:    v = 18'sd16384;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/comfort_noise_mixer.sv */
// Comfort noise mixer: one shared multiplier and accumulator run three biquad
// sections and the gain mix under a step sequencer. Uses cnm_pkg.
// Words are processed one at a time: a new input word is taken only while the sequencer
// is idle, after the 8 steps per section of the shared multiply-accumulate unit plus 3
// mix steps for the previous word; a stalled output holds the sequencer in its mix output step.
// Reset (synchronous, rst_n low): sequencer idle, delays back to 3.0/2.0/1.0, gain 0.
module comfort_noise_mixer #(
  parameter int STATE_WIDTH = cnm_pkg::STATE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cnm_pkg::GAIN_W-1:0]          cfg_noise_gain,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cnm_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [cnm_pkg::WORD_W-1:0]          in_random_word,
  input  logic                                in_last_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cnm_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_last_out
);
  import cnm_pkg::*;

  localparam int W      = STATE_WIDTH;
  localparam int OPA_W  = GAIN_W + 1;
  localparam int PROD_W = W + OPA_W;
  localparam int ACC_W  = W + 20;

  localparam logic signed [ACC_W-1:0] SAT_HI   = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO   = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_ACC  = ACC_W'(ROUND_Q14);
  localparam logic signed [ACC_W-1:0] MIX_BIAS = ACC_W'((1 << MIX_SHIFT) - 1);
  localparam logic signed [ACC_W-1:0] OUT_HI   = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] OUT_LO   = ACC_W'(SAMPLE_MIN);
  localparam logic signed [W:0]       Q2_RND   = (W+1)'(ROUND_Q2);

  state_t   state_r, state_nxt;
  step_t    step_r, step_nxt;
  sec_idx_t sec_r, sec_nxt;
  ctrl_t    ctrl;

  logic [GAIN_W-1:0]          gain_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_r;
  logic signed [W-1:0]        x_r;
  logic signed [W-1:0]        y_r;
  logic signed [W-1:0]        d0_r [NUM_SECTIONS];
  logic signed [W-1:0]        d1_r [NUM_SECTIONS];
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  logic signed [OPA_W-1:0]    opa;
  logic signed [W-1:0]        opb;
  logic signed [W:0]          y_rnd;
  logic signed [PROD_W-1:0]   mul_full;
  logic signed [ACC_W-1:0]    acc_q14;
  logic signed [W-1:0]        addend;
  logic signed [ACC_W-1:0]    sat_arg;
  logic signed [W-1:0]        sat_res;
  logic signed [WORD_W:0]     noise_ctr;
  logic signed [ACC_W-1:0]    mix_q;
  logic signed [SAMPLE_W-1:0] mix_res;
  logic                       in_take;
  logic                       out_blocked;

  assign cfg_ready      = 1'b1;
  assign in_stall       = (state_r != ST_IDLE);
  assign in_take        = in_valid && !in_stall;
  assign out_blocked    = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sec_nxt   = sec_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SEC;
          step_nxt  = SP_MUL_B0;
          sec_nxt   = '0;
        end
      end
      ST_SEC: begin
        step_nxt = step_t'(STEP_W'(step_r) + STEP_W'(1));
        if (step_r == SP_UPD_D1) begin
          if (sec_r == SEC_W'(NUM_SECTIONS - 1)) begin
            state_nxt = ST_MIX_MUL;
          end else begin
            sec_nxt = sec_r + SEC_W'(1);
          end
        end
      end
      ST_MIX_MUL: state_nxt = ST_MIX_ACC;
      ST_MIX_ACC: state_nxt = ST_MIX_OUT;
      ST_MIX_OUT: begin
        if (!out_blocked) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: one micro-operation per step.
  always_comb begin
    ctrl = '{coef: CO_B0, opb: OPB_X, acc_op: ACC_HOLD, y_we: 1'b0, d0_we: 1'b0,
             d1_we: 1'b0, x_adv: 1'b0, out_load: 1'b0};
    case (state_r)
      ST_SEC: begin
        case (step_r)
          SP_MUL_B0: begin
            ctrl.coef = CO_B0;
          end
          SP_MUL_B1: begin
            ctrl.acc_op = ACC_LOAD_RND;
            ctrl.coef   = CO_B1;
          end
          SP_OUT_Y: begin
            ctrl.y_we   = 1'b1;
            ctrl.acc_op = ACC_LOAD_RND;
          end
          SP_MUL_A1: begin
            ctrl.coef = CO_NA1;
            ctrl.opb  = OPB_Y;
          end
          SP_MUL_B2: begin
            ctrl.acc_op = ACC_ADD;
            ctrl.coef   = CO_B2;
          end
          SP_UPD_D0: begin
            ctrl.d0_we  = 1'b1;
            ctrl.acc_op = ACC_LOAD_RND;
            ctrl.coef   = CO_NA2;
            ctrl.opb    = OPB_Y;
          end
          SP_ACC_A2: begin
            ctrl.acc_op = ACC_ADD;
          end
          SP_UPD_D1: begin
            ctrl.d1_we = 1'b1;
            ctrl.x_adv = 1'b1;
          end
          default: ctrl.coef = CO_B0;
        endcase
      end
      ST_MIX_MUL: ctrl.opb = OPB_YQ2;
      ST_MIX_ACC: ctrl.acc_op = ACC_LOAD_MIX;
      ST_MIX_OUT: ctrl.out_load = !out_blocked;
      default: ctrl.coef = CO_B0;
    endcase
  end

  // Shared multiplier operands.
  always_comb begin
    y_rnd = (W+1)'(x_r) + Q2_RND;
    case (ctrl.opb)
      OPB_X:   opb = x_r;
      OPB_Y:   opb = y_r;
      OPB_YQ2: opb = W'(y_rnd >>> Q2_SHIFT);
      default: opb = x_r;
    endcase
    if (ctrl.opb == OPB_YQ2) begin
      opa = signed'({1'b0, gain_r});
    end else begin
      opa = OPA_W'(coef_lookup(sec_r, ctrl.coef));
    end
  end

  assign mul_full = opa * opb;

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD_RND: acc_nxt = ACC_W'(prod_r) + RND_ACC;
      ACC_ADD:      acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_LOAD_MIX: acc_nxt = (ACC_W'(sample_r) <<< MIX_SHIFT) + ACC_W'(prod_r);
      default:      acc_nxt = acc_r;
    endcase
  end

  // Rounding, delay add and state saturation.
  always_comb begin
    acc_q14 = acc_r >>> FRAC_BITS;
    if (ctrl.y_we) begin
      addend = d0_r[sec_r];
    end else if (ctrl.d0_we) begin
      addend = d1_r[sec_r];
    end else begin
      addend = '0;
    end
    sat_arg = acc_q14 + ACC_W'(addend);
    if (sat_arg > SAT_HI) begin
      sat_res = W'(SAT_HI);
    end else if (sat_arg < SAT_LO) begin
      sat_res = W'(SAT_LO);
    end else begin
      sat_res = W'(sat_arg);
    end
  end

  // Truncation toward zero and output saturation.
  always_comb begin
    mix_q = (acc_r + (acc_r[ACC_W-1] ? MIX_BIAS : ACC_W'(0))) >>> MIX_SHIFT;
    if (mix_q > OUT_HI) begin
      mix_res = SAMPLE_W'(SAMPLE_MAX);
    end else if (mix_q < OUT_LO) begin
      mix_res = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      mix_res = SAMPLE_W'(mix_q);
    end
  end

  assign noise_ctr = signed'({1'b0, in_random_word}) - (WORD_W+1)'(NOISE_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_MUL_B0;
      sec_r       <= '0;
      gain_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        d0_r[SEC_W'(i)] <= W'(delay_reset(SEC_W'(i)));
        d1_r[SEC_W'(i)] <= W'(delay_reset(SEC_W'(i)));
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= ctrl.out_load || out_blocked;
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_noise_gain;
      end
      if (ctrl.d0_we) begin
        d0_r[sec_r] <= sat_res;
      end
      if (ctrl.d1_we) begin
        d1_r[sec_r] <= sat_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_full;
    acc_r  <= acc_nxt;
    if (in_take) begin
      sample_r <= in_sample_in;
      last_r   <= in_last_in;
      x_r      <= W'(noise_ctr) <<< FRAC_BITS;
    end else if (ctrl.x_adv) begin
      x_r <= y_r;
    end
    if (ctrl.y_we) begin
      y_r <= sat_res;
    end
    if (ctrl.out_load) begin
      out_sample_r <= mix_res;
      out_last_r   <= last_r;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_SEC && step_r == SP_MUL_B0 && sec_r == '0)
    else $error("accepted word did not start the first section");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r <= SEC_W'(NUM_SECTIONS - 1))
    else $error("section index out of range");

  a_mix_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEC && step_r == SP_UPD_D1 && sec_r == SEC_W'(NUM_SECTIONS - 1)
    |=> state_r == ST_MIX_MUL)
    else $error("mix did not follow the last section");

  a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_MIX_OUT && state_r == ST_IDLE)
    else $error("output word loaded outside the mix step");

endmodule
